// ===== design/vmse_pkg.sv =====
// shared types, constants and arithmetic helpers for the stereo echo mixer
// no dependencies; every design file but the checker imports this package
package vmse_pkg;

	localparam int ECHO_DEPTH = 16384;
	localparam int ECHO_AW    = $clog2(ECHO_DEPTH);
	localparam int CNT_W      = ECHO_AW + 1;
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 15;
	localparam int CFG_IDX_W  = 1;
	localparam int RECIP_SHIFT = 17;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_LEN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LEN = 1'd1;

	localparam logic [LEN_W-1:0] LEFT_LEN_RESET  = 15'd11025;
	localparam logic [LEN_W-1:0] RIGHT_LEN_RESET = 15'd14700;

	// ceil(2^17 / 3), exact for magnitudes below 2^17
	localparam logic [15:0] RECIP_3 = 16'd43691;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t sum;
		logic    ovf;
	} add_res_t;

	// frame totals including the item now offered
	typedef struct packed {
		sample_t dry_l;
		sample_t dry_r;
		sample_t aux_l;
		sample_t aux_r;
		logic    wrap;
	} mix_tot_t;

	// echo pipeline control, one bit per stage
	typedef struct packed {
		logic start;
		logic v_s1;
		logic v_s2;
	} echo_ctl_t;

	// 16-bit wrapping add with overflow flag
	function automatic add_res_t add16(sample_t a, sample_t b);
		logic signed [SAMPLE_W:0] s;
		add_res_t r;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		r.sum = s[SAMPLE_W-1:0];
		r.ovf = s[SAMPLE_W] ^ s[SAMPLE_W-1];
		return r;
	endfunction

	// halve, rounding toward zero
	function automatic sample_t half_tz(sample_t v);
		logic signed [SAMPLE_W:0] t;
		logic signed [SAMPLE_W:0] h;
		t = {v[SAMPLE_W-1], v} + {{SAMPLE_W{1'b0}}, v[SAMPLE_W-1]};
		h = t >>> 1;
		return h[SAMPLE_W-1:0];
	endfunction

	// delay length clamped to 1..ECHO_DEPTH
	function automatic logic [CNT_W-1:0] eff_len(logic [LEN_W-1:0] len);
		int l;
		l = int'(len);
		if (l == 0) begin
			l = 1;
		end else if (l > ECHO_DEPTH) begin
			l = ECHO_DEPTH;
		end
		return CNT_W'(l);
	endfunction

endpackage

// ===== design/vmse_echo_ram.sv =====
// one echo delay store: single write port, single registered read port
// depends on vmse_pkg for depth and sample width
module vmse_echo_ram (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [vmse_pkg::ECHO_AW-1:0] rd_addr,
	output vmse_pkg::sample_t            rd_data,
	input  logic                         wr_en,
	input  logic [vmse_pkg::ECHO_AW-1:0] wr_addr,
	input  vmse_pkg::sample_t            wr_data
);
	import vmse_pkg::*;

	sample_t mem [ECHO_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/vmse_echo_lane.sv =====
// one echo channel: tap pointer, fill count, delay store and the
// read / scale by two thirds / add / write-back pipeline
// depends on vmse_pkg and vmse_echo_ram
module vmse_echo_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vmse_pkg::echo_ctl_t        ctl,
	input  logic [vmse_pkg::LEN_W-1:0] len,
	input  vmse_pkg::sample_t          aux_in,
	output vmse_pkg::sample_t          echo_sum,
	output logic                       echo_wrap
);
	import vmse_pkg::*;

	logic [ECHO_AW-1:0] pos_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   pos_inc;
	logic [ECHO_AW-1:0] pos_nxt;

	logic [ECHO_AW-1:0] p_s1;
	sample_t            aux_s1;
	sample_t            rd_data;
	logic               hit;
	sample_t            tap;
	logic signed [SAMPLE_W:0] tap2;
	logic [SAMPLE_W:0]  mag;
	logic [SAMPLE_W+SAMPLE_W:0] prod;

	logic [ECHO_AW-1:0] p_s2;
	sample_t            aux_s2;
	logic               neg_s2;
	logic [SAMPLE_W+SAMPLE_W:0] prod_s2;
	sample_t            q;
	sample_t            tap23;
	add_res_t           res;

	assign pos_inc = {1'b0, pos_q} + CNT_W'(1);
	assign pos_nxt = (pos_inc >= eff_len(len)) ? '0 : pos_inc[ECHO_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.start) begin
				pos_q <= pos_nxt;
			end
			// written entries always form a run from zero
			if (ctl.v_s2 && ({1'b0, p_s2} == fill_q)) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	vmse_echo_ram u_ram (
		.clk     (clk),
		.rd_en   (ctl.start),
		.rd_addr (pos_q),
		.rd_data (rd_data),
		.wr_en   (ctl.v_s2),
		.wr_addr (p_s2),
		.wr_data (res.sum)
	);

	// s1: tap from store (unwritten reads as zero), magnitude times 1/3
	assign hit  = ({1'b0, p_s1} < fill_q);
	assign tap  = hit ? rd_data : '0;
	assign tap2 = {tap, 1'b0};
	assign mag  = tap[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - tap2) : tap2;
	assign prod = {{SAMPLE_W{1'b0}}, mag} * {{(SAMPLE_W+1){1'b0}}, RECIP_3};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			p_s1   <= pos_q;
			aux_s1 <= aux_in;
		end
		if (ctl.v_s1) begin
			p_s2    <= p_s1;
			aux_s2  <= aux_s1;
			neg_s2  <= tap[SAMPLE_W-1];
			prod_s2 <= prod;
		end
	end

	// s2: restore sign, add to aux bus, write back
	assign q     = prod_s2[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
	assign tap23 = neg_s2 ? (sample_t'(0) - q) : q;
	assign res   = add16(aux_s2, tap23);

	assign echo_sum  = res.sum;
	assign echo_wrap = res.ovf;

endmodule

// ===== design/vmse_mix_acc.sv =====
// dry and aux bus accumulators with the per-frame wrap flag
// depends on vmse_pkg
module vmse_mix_acc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  vmse_pkg::sample_t  voice_left,
	input  vmse_pkg::sample_t  voice_right,
	input  logic               voice_present,
	input  logic               send_to_aux,
	input  logic               frame_end,
	output vmse_pkg::mix_tot_t tot
);
	import vmse_pkg::*;

	sample_t  dry_l_q, dry_r_q, aux_l_q, aux_r_q;
	logic     wrap_q;
	sample_t  hl, hr;
	add_res_t a_dl, a_dr, a_al, a_ar;

	assign hl   = half_tz(voice_left);
	assign hr   = half_tz(voice_right);
	assign a_dl = add16(dry_l_q, hl);
	assign a_dr = add16(dry_r_q, hr);
	assign a_al = add16(aux_l_q, hl);
	assign a_ar = add16(aux_r_q, hr);

	always_comb begin
		tot.dry_l = dry_l_q;
		tot.dry_r = dry_r_q;
		tot.aux_l = aux_l_q;
		tot.aux_r = aux_r_q;
		tot.wrap  = wrap_q;
		if (voice_present) begin
			tot.dry_l = a_dl.sum;
			tot.dry_r = a_dr.sum;
			tot.wrap  = tot.wrap | a_dl.ovf | a_dr.ovf;
			if (send_to_aux) begin
				tot.aux_l = a_al.sum;
				tot.aux_r = a_ar.sum;
				tot.wrap  = tot.wrap | a_al.ovf | a_ar.ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_l_q <= '0;
			dry_r_q <= '0;
			aux_l_q <= '0;
			aux_r_q <= '0;
			wrap_q  <= 1'b0;
		end else if (take) begin
			if (frame_end) begin
				dry_l_q <= '0;
				dry_r_q <= '0;
				aux_l_q <= '0;
				aux_r_q <= '0;
				wrap_q  <= 1'b0;
			end else begin
				dry_l_q <= tot.dry_l;
				dry_r_q <= tot.dry_r;
				aux_l_q <= tot.aux_l;
				aux_r_q <= tot.aux_r;
				wrap_q  <= tot.wrap;
			end
		end
	end

endmodule

// ===== design/voice_mixer_stereo_echo_core.sv =====
// stereo voice mixer with feedback echo; a frame-end transfer reaches m_tvalid through
// the s1 store read, s2 multiply and output add; voice transfers one per cycle, while a
// frame end waits until the echo pipe is empty and the output slot frees, as set by the
// read-modify-write of the echo stores through their single port pair
// reset: arst_n clears buses, tap pointers and fill counts; store contents stay as
// they are, entries beyond the fill count read as zero, so there is no clearing pass
module voice_mixer_stereo_echo_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side: tdata = voice_left[15:0], voice_right[31:16]
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,
	// tuser = voice_present[0], send_to_aux[1]
	input  logic [1:0]                     s_tuser,
	// tlast = frame_end
	input  logic                           s_tlast,
	// master side: tdata = out_left[15:0], out_right[31:16]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,
	// tuser = wrapped[0]
	output logic                           m_tuser,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [vmse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vmse_pkg::LEN_W-1:0]     cfg_data
);
	import vmse_pkg::*;

	// delay length registers
	logic [LEN_W-1:0] left_len_q, right_len_q;

	// pipeline control
	logic v_s1_q, v_s2_q, out_valid_q;
	logic fe_ok, take, fe_take;
	echo_ctl_t ctl;

	mix_tot_t tot;

	// dry bus and frame flag travel beside the echo lanes
	sample_t dry_l_s1, dry_r_s1, dry_l_s2, dry_r_s2;
	logic    flag_s1, flag_s2;

	sample_t  echo_l, echo_r;
	logic     ewrap_l, ewrap_r;
	add_res_t o_l, o_r;

	sample_t out_l_q, out_r_q;
	logic    out_wrap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_len_q  <= LEFT_LEN_RESET;
			right_len_q <= RIGHT_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT_LEN:  left_len_q  <= cfg_data;
				REG_RIGHT_LEN: right_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a frame end waits until the echo pipe is empty and the output slot frees,
	// so no store read can meet a pending write-back of the same entry
	assign fe_ok    = !v_s1_q && !v_s2_q && (!out_valid_q || m_tready);
	assign s_tready = !s_tlast || fe_ok;
	assign take     = s_tvalid && s_tready;
	assign fe_take  = take && s_tlast;

	assign ctl.start = fe_take;
	assign ctl.v_s1  = v_s1_q;
	assign ctl.v_s2  = v_s2_q;

	vmse_mix_acc u_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.voice_left    (s_tdata[15:0]),
		.voice_right   (s_tdata[31:16]),
		.voice_present (s_tuser[0]),
		.send_to_aux   (s_tuser[1]),
		.frame_end     (s_tlast),
		.tot           (tot)
	);

	vmse_echo_lane u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.len       (left_len_q),
		.aux_in    (tot.aux_l),
		.echo_sum  (echo_l),
		.echo_wrap (ewrap_l)
	);

	vmse_echo_lane u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.len       (right_len_q),
		.aux_in    (tot.aux_r),
		.echo_sum  (echo_r),
		.echo_wrap (ewrap_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1_q <= fe_take;
			v_s2_q <= v_s1_q;
			if (v_s2_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fe_take) begin
			dry_l_s1 <= tot.dry_l;
			dry_r_s1 <= tot.dry_r;
			flag_s1  <= tot.wrap;
		end
		if (v_s1_q) begin
			dry_l_s2 <= dry_l_s1;
			dry_r_s2 <= dry_r_s1;
			flag_s2  <= flag_s1;
		end
	end

	// final mix: dry plus half the echoed aux, floor
	assign o_l = add16(dry_l_s2, echo_l >>> 1);
	assign o_r = add16(dry_r_s2, echo_r >>> 1);

	always_ff @(posedge clk) begin
		if (v_s2_q) begin
			out_l_q    <= o_l.sum;
			out_r_q    <= o_r.sum;
			out_wrap_q <= flag_s2 | ewrap_l | ewrap_r | o_l.ovf | o_r.ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_r_q, out_l_q};
	assign m_tuser  = out_wrap_q;

endmodule

// ===== design/vmse_checker.sv =====
// port-level checks for the stereo echo mixer, bound to the top level
// watches only the handshake ports, no package needed
module vmse_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tlast,
	input logic m_tvalid,
	input logic m_tready
);

	// a result stays offered until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before transfer");

	// no result while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// only frame-end items are ever held back
	a_voice_flow: assert property (@(posedge clk) !s_tready |-> s_tlast)
		else $error("voice item stalled");

	// every frame end produces a result
	a_fe_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> ##2 m_tvalid)
		else $error("frame end without result");

	// a new result only follows a frame-end transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 3))
		else $error("result without frame end");

endmodule

bind voice_mixer_stereo_echo_core vmse_checker u_vmse_checker (.*);
